>>> hdl/bbcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcg_pkg
// Shared types and constants for the barometer baseline calibrator: sample
// set size, field widths, opcodes, status codes and the chain interfaces.
// ----------------------------------------------------------------------------
package bbcg_pkg;

   localparam int unsigned CAL_COUNT = 100;

   localparam int unsigned P_W      = 21;
   localparam int unsigned REL_W    = 22;
   localparam int unsigned STEP_W   = 16;
   localparam int unsigned STATUS_W = 2;

   localparam int unsigned CNT_W = $clog2(CAL_COUNT + 1);
   localparam int unsigned SUM_W = P_W + $clog2(CAL_COUNT);

   // mean = (sum + C/2) / C via reciprocal multiply and one correction
   localparam int unsigned RECIP_SH = 32;
   localparam int unsigned RECIP_W  = 33 - $clog2(CAL_COUNT);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / CAL_COUNT);
   localparam int unsigned PROD_W   = SUM_W + RECIP_W;

   localparam int unsigned Q1_LO_IDX = CAL_COUNT / 4 - 1;
   localparam int unsigned Q1_HI_IDX = CAL_COUNT / 4;
   localparam int unsigned Q3_LO_IDX = 3 * CAL_COUNT / 4 - 1;
   localparam int unsigned Q3_HI_IDX = 3 * CAL_COUNT / 4;

   localparam logic [STEP_W-1:0] GATE_STEP_RESET = 16'd259;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_ARM    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_COLLECT = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MEASURE = 2'd3;

   typedef struct packed {
      logic insert;
      logic clear;
   } chain_ctrl_type;

   typedef struct packed {
      logic [P_W-1:0] min_value;
      logic [P_W-1:0] max_value;
      logic [P_W-1:0] q1_lo;
      logic [P_W-1:0] q1_hi;
      logic [P_W-1:0] q3_lo;
      logic [P_W-1:0] q3_hi;
   } chain_taps_type;

endpackage

>>> hdl/bbcg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcg_cell
// One slot of the sorted insertion chain. Holds a sample; on insert it takes
// the new sample, its left neighbour's sample, or keeps its own.
// ----------------------------------------------------------------------------
module bbcg_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  bbcg_pkg::chain_ctrl_type   ctrl,
   input  logic [bbcg_pkg::P_W-1:0]   new_value,
   input  logic [bbcg_pkg::P_W-1:0]   prev_value,
   input  logic                       prev_valid,
   input  logic                       prev_take,
   output logic [bbcg_pkg::P_W-1:0]   value,
   output logic                       valid,
   output logic                       take
);

   logic [bbcg_pkg::P_W-1:0] value_ff;
   logic                     valid_ff;

   // new sample belongs here or further left
   assign take  = !valid_ff || (new_value < value_ff);
   assign value = value_ff;
   assign valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.insert) begin
         if (prev_take) begin
            valid_ff <= prev_valid;
         end else if (take) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert) begin
         if (prev_take) begin
            value_ff <= prev_value;
         end else if (take) begin
            value_ff <= new_value;
         end
      end
   end

endmodule

>>> hdl/bbcg_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcg_chain
// Row of insertion cells keeping the calibration set sorted ascending.
// Exposes the extreme and quartile taps.
// ----------------------------------------------------------------------------
module bbcg_chain (
   input  logic                       clock,
   input  logic                       reset,
   input  bbcg_pkg::chain_ctrl_type   ctrl,
   input  logic [bbcg_pkg::P_W-1:0]   new_value,
   output bbcg_pkg::chain_taps_type   taps
);

   logic [bbcg_pkg::P_W-1:0] value [bbcg_pkg::CAL_COUNT];
   logic                     valid [bbcg_pkg::CAL_COUNT];
   logic                     take  [bbcg_pkg::CAL_COUNT];

   genvar i;
   generate
      for (i = 0; i < bbcg_pkg::CAL_COUNT; i++) begin : g_cell
         if (i == 0) begin : g_head
            bbcg_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (ctrl),
               .new_value  (new_value),
               .prev_value (new_value),
               .prev_valid (1'b0),
               .prev_take  (1'b0),
               .value      (value[i]),
               .valid      (valid[i]),
               .take       (take[i])
            );
         end else begin : g_body
            bbcg_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (ctrl),
               .new_value  (new_value),
               .prev_value (value[i-1]),
               .prev_valid (valid[i-1]),
               .prev_take  (take[i-1]),
               .value      (value[i]),
               .valid      (valid[i]),
               .take       (take[i])
            );
         end
      end
   endgenerate

   assign taps.min_value = value[0];
   assign taps.max_value = value[bbcg_pkg::CAL_COUNT-1];
   assign taps.q1_lo     = value[bbcg_pkg::Q1_LO_IDX];
   assign taps.q1_hi     = value[bbcg_pkg::Q1_HI_IDX];
   assign taps.q3_lo     = value[bbcg_pkg::Q3_LO_IDX];
   assign taps.q3_hi     = value[bbcg_pkg::Q3_HI_IDX];

endmodule

>>> hdl/baro_baseline_calibrate_and_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_baseline_calibrate_and_gate
// Barometer baseline calibration with interquartile outlier check and a
// slew-limited relative pressure output.
//
//   port group   direction  handshake          payload
//   req_*        in         valid / stall      opcode, pressure_sample
//   rsp_*        out        valid / stall      rel_pressure, status, clamped
//   csr_*        in         valid / ready      data (gate_step)
//
// The sample completing a calibration passes through a quartile and
// reciprocal-multiply stage, a bound and remainder stage, a decision stage.
// Collection inserts into the sorted cell chain, one sample per cycle
// while req_stall is low. Synchronous reset clears control state;
// csr_ready is always high. A two-entry result queue lets the block take
// items while rsp_stall holds, until both entries are full.
// ----------------------------------------------------------------------------
module baro_baseline_calibrate_and_gate (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [bbcg_pkg::P_W-1:0]          req_pressure_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bbcg_pkg::REL_W-1:0] rsp_rel_pressure,
   output logic [bbcg_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_clamped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bbcg_pkg::STEP_W-1:0]       csr_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_QUART = 2'd1;
   localparam logic [1:0] S_BOUND = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   localparam int unsigned P_W   = bbcg_pkg::P_W;
   localparam int unsigned REL_W = bbcg_pkg::REL_W;
   localparam int unsigned CNT_W = bbcg_pkg::CNT_W;
   localparam int unsigned SUM_W = bbcg_pkg::SUM_W;
   localparam int unsigned ST_W  = bbcg_pkg::STATUS_W;

   // control and state
   logic [1:0]                      state_ff, state_in;
   logic                            armed_ff, armed_in;
   logic                            calibrated_ff, calibrated_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic [P_W-1:0]                  baseline_ff, baseline_in;
   logic signed [REL_W-1:0]         last_ff, last_in;
   logic [bbcg_pkg::STEP_W-1:0]     gate_step_ff;

   // calibration datapath
   logic [P_W:0]                    q1x2_ff, q3x2_ff;
   logic [P_W-1:0]                  qest_ff;
   logic [P_W+2:0]                  hi_ff;
   logic signed [P_W+3:0]           lo_ff;
   logic                            corr_ff;

   // result queue
   logic                            head_valid_ff, head_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   logic signed [REL_W-1:0]         head_rel_ff, skid_rel_ff;
   logic [ST_W-1:0]                 head_status_ff, skid_status_ff;
   logic                            head_clamped_ff, skid_clamped_ff;

   logic                            accept, pop;
   logic                            push;
   logic signed [REL_W-1:0]         push_rel;
   logic [ST_W-1:0]                 push_status;
   logic                            push_clamped;

   bbcg_pkg::chain_ctrl_type        chain_ctrl;
   bbcg_pkg::chain_taps_type        taps;

   logic [SUM_W-1:0]                mean_num;
   logic [bbcg_pkg::PROD_W-1:0]     mean_prod;
   logic [SUM_W-1:0]                mean_rem;
   logic [P_W:0]                    iqrx2;
   logic [P_W+2:0]                  max_x2;
   logic signed [P_W+3:0]           min_x2;
   logic                            outlier;

   logic signed [REL_W:0]           rel, lim_lo, lim_hi, meas;
   logic                            meas_clamped;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || skid_valid_ff;
   assign pop       = head_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   bbcg_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chain_ctrl),
      .new_value (req_pressure_sample),
      .taps      (taps)
   );

   // mean and outlier bounds
   assign mean_num  = sum_ff + SUM_W'(bbcg_pkg::CAL_COUNT / 2);
   assign mean_prod = bbcg_pkg::PROD_W'(mean_num) * bbcg_pkg::PROD_W'(bbcg_pkg::RECIP);
   assign mean_rem  = mean_num - SUM_W'(qest_ff * SUM_W'(bbcg_pkg::CAL_COUNT));
   assign iqrx2     = q3x2_ff - q1x2_ff;
   assign max_x2    = {2'b00, taps.max_value, 1'b0};
   assign min_x2    = $signed({3'b000, taps.min_value, 1'b0});
   assign outlier   = (max_x2 > hi_ff) || (min_x2 < lo_ff);

   // slew limit
   always_comb begin
      rel          = $signed({2'b00, baseline_ff}) - $signed({2'b00, req_pressure_sample});
      lim_lo       = $signed({last_ff[REL_W-1], last_ff})
                     - $signed({{(REL_W-bbcg_pkg::STEP_W+1){1'b0}}, gate_step_ff});
      lim_hi       = $signed({last_ff[REL_W-1], last_ff})
                     + $signed({{(REL_W-bbcg_pkg::STEP_W+1){1'b0}}, gate_step_ff});
      meas         = rel;
      meas_clamped = 1'b0;
      priority if (rel < lim_lo) begin
         meas         = lim_lo;
         meas_clamped = 1'b1;
      end else if (rel > lim_hi) begin
         meas         = lim_hi;
         meas_clamped = 1'b1;
      end
   end

   always_comb begin
      state_in          = state_ff;
      armed_in          = armed_ff;
      calibrated_in     = calibrated_ff;
      count_in          = count_ff;
      sum_in            = sum_ff;
      baseline_in       = baseline_ff;
      last_in           = last_ff;
      chain_ctrl.insert = 1'b0;
      chain_ctrl.clear  = 1'b0;
      push              = 1'b0;
      push_rel          = '0;
      push_status       = bbcg_pkg::STATUS_COLLECT;
      push_clamped      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == bbcg_pkg::OP_ARM) begin
                  armed_in = 1'b1;
               end else if (armed_ff && !calibrated_ff) begin
                  if (count_ff != CNT_W'(bbcg_pkg::CAL_COUNT)) begin
                     chain_ctrl.insert = 1'b1;
                     sum_in            = sum_ff + SUM_W'(req_pressure_sample);
                     count_in          = count_ff + 1'b1;
                     last_in           = '0;
                     push              = 1'b1;
                  end else begin
                     state_in = S_QUART;
                  end
               end else begin
                  last_in      = meas[REL_W-1:0];
                  push         = 1'b1;
                  push_rel     = meas[REL_W-1:0];
                  push_status  = bbcg_pkg::STATUS_MEASURE;
                  push_clamped = meas_clamped;
               end
            end
         end
         S_QUART: begin
            state_in = S_BOUND;
         end
         S_BOUND: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
            push     = 1'b1;
            if (outlier) begin
               count_in         = '0;
               sum_in           = '0;
               chain_ctrl.clear = 1'b1;
               push_status      = bbcg_pkg::STATUS_REJECT;
            end else begin
               calibrated_in = 1'b1;
               baseline_in   = qest_ff + P_W'(corr_ff);
               push_status   = bbcg_pkg::STATUS_ACCEPT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         armed_ff      <= 1'b0;
         calibrated_ff <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= '0;
         baseline_ff   <= '0;
         last_ff       <= '0;
         gate_step_ff  <= bbcg_pkg::GATE_STEP_RESET;
      end else begin
         state_ff      <= state_in;
         armed_ff      <= armed_in;
         calibrated_ff <= calibrated_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         baseline_ff   <= baseline_in;
         last_ff       <= last_in;
         if (csr_valid && csr_ready) begin
            gate_step_ff <= csr_data;
         end
      end
   end

   // calibration pipeline registers
   always_ff @(posedge clock) begin
      if (state_ff == S_QUART) begin
         q1x2_ff <= {1'b0, taps.q1_lo} + {1'b0, taps.q1_hi};
         q3x2_ff <= {1'b0, taps.q3_lo} + {1'b0, taps.q3_hi};
         qest_ff <= mean_prod[bbcg_pkg::RECIP_SH +: P_W];
      end
      if (state_ff == S_BOUND) begin
         hi_ff   <= {2'b00, q3x2_ff} + {1'b0, iqrx2, 1'b0};
         lo_ff   <= $signed({3'b000, q1x2_ff}) - $signed({2'b00, iqrx2, 1'b0});
         corr_ff <= mean_rem >= SUM_W'(bbcg_pkg::CAL_COUNT);
      end
   end

   // result queue: head drives the port, skid catches one item under stall
   always_comb begin
      head_valid_in = skid_valid_ff || push || (head_valid_ff && !pop);
      if (!head_valid_ff || pop) begin
         skid_valid_in = skid_valid_ff && push;
      end else begin
         skid_valid_in = skid_valid_ff || push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_rel_ff     <= skid_rel_ff;
            head_status_ff  <= skid_status_ff;
            head_clamped_ff <= skid_clamped_ff;
         end else begin
            head_rel_ff     <= push_rel;
            head_status_ff  <= push_status;
            head_clamped_ff <= push_clamped;
         end
      end
      if (push && (skid_valid_ff || (head_valid_ff && !pop))) begin
         skid_rel_ff     <= push_rel;
         skid_status_ff  <= push_status;
         skid_clamped_ff <= push_clamped;
      end
   end

   assign rsp_valid        = head_valid_ff;
   assign rsp_rel_pressure = head_rel_ff;
   assign rsp_status       = head_status_ff;
   assign rsp_clamped      = head_clamped_ff;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the barometer baseline calibrator. A built-in
// predictor follows every accepted item and queues results for non-arm items.
// Stimulus covers pre-arm slew limiting, rejected and accepted calibration
// sets (outliers, quartile-bound edges, flat sets) and measurements under
// a range of gate steps, with random idling on both channels and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   import bbcg_pkg::*;

   localparam int unsigned P_MAX      = (1 << P_W) - 1;
   localparam int unsigned TIMEOUT_NS = 1_000_000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

   typedef enum int {
      SET_OUTLIER_HIGH, SET_OUTLIER_LOW, SET_EDGE_HIGH, SET_EDGE_LOW, SET_FLAT,
      SET_EDGE_ACCEPT
   } cal_shape_e;

   typedef struct packed {
      logic signed [REL_W-1:0] rel_pressure;
      logic [STATUS_W-1:0]     status;
      logic                    clamped;
   } baro_result_t;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_opcode;
   logic [P_W-1:0]          req_pressure_sample;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [REL_W-1:0] rsp_rel_pressure;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_clamped;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [STEP_W-1:0]       csr_data;

   // predictor state
   logic [STEP_W-1:0]       gate_step_q  = GATE_STEP_RESET;
   logic                    armed_q      = 1'b0;
   logic                    calibrated_q = 1'b0;
   int unsigned             cal_count_q  = 0;
   logic [P_W-1:0]          cal_set_q [CAL_COUNT];
   logic [SUM_W-1:0]        cal_sum_q    = '0;
   logic [P_W-1:0]          baseline_q   = '0;
   logic signed [REL_W-1:0] last_rel_q   = '0;

   baro_result_t expected_results [$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_cycles   = 0;
   int unsigned items_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned mismatches    = 0;
   int unsigned rejects       = 0;
   int unsigned accepts       = 0;
   int unsigned clamps        = 0;

   baro_baseline_calibrate_and_gate DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_pressure_sample (req_pressure_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rel_pressure    (rsp_rel_pressure),
      .rsp_status          (rsp_status),
      .rsp_clamped         (rsp_clamped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic bit calibration_passes();
      logic [P_W-1:0] s [CAL_COUNT];
      logic [P_W-1:0] v;
      int             j;
      longint         q1x2, q3x2, iqrx2, hi_x2, lo_x2;
      baseline_q = P_W'((cal_sum_q + CAL_COUNT / 2) / CAL_COUNT);
      s = cal_set_q;
      for (int i = 1; i < CAL_COUNT; i++) begin
         v = s[i];
         j = i;
         while (j > 0 && s[j-1] > v) begin
            s[j] = s[j-1];
            j--;
         end
         s[j] = v;
      end
      // quartiles kept doubled so the bounds stay exact
      q1x2  = longint'(s[Q1_LO_IDX]) + longint'(s[Q1_HI_IDX]);
      q3x2  = longint'(s[Q3_LO_IDX]) + longint'(s[Q3_HI_IDX]);
      iqrx2 = q3x2 - q1x2;
      hi_x2 = q3x2 + 2 * iqrx2;
      lo_x2 = q1x2 - 2 * iqrx2;
      for (int i = 0; i < CAL_COUNT; i++) begin
         if (2 * longint'(s[i]) > hi_x2 || 2 * longint'(s[i]) < lo_x2) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit predict_item(input logic op, input logic [P_W-1:0] p,
                                       output baro_result_t r);
      logic signed [REL_W+1:0] rel, prev, step, res;
      r.rel_pressure = '0;
      r.status       = STATUS_COLLECT;
      r.clamped      = 1'b0;
      if (op == OP_ARM) begin
         armed_q = 1'b1;
         return 1'b0;
      end
      if (armed_q && !calibrated_q) begin
         if (cal_count_q < CAL_COUNT) begin
            cal_set_q[cal_count_q] = p;
            cal_sum_q   = cal_sum_q + p;
            cal_count_q = cal_count_q + 1;
            last_rel_q  = '0;
         end else if (calibration_passes()) begin
            calibrated_q = 1'b1;
            r.status     = STATUS_ACCEPT;
         end else begin
            cal_count_q = 0;
            cal_sum_q   = '0;
            r.status    = STATUS_REJECT;
         end
      end else begin
         rel  = $signed({3'b0, baseline_q}) - $signed({3'b0, p});
         prev = last_rel_q;
         step = $signed({8'b0, gate_step_q});
         res  = rel;
         if (rel < prev - step) begin
            res       = prev - step;
            r.clamped = 1'b1;
         end else if (rel > prev + step) begin
            res       = prev + step;
            r.clamped = 1'b1;
         end
         last_rel_q     = res[REL_W-1:0];
         r.rel_pressure = res[REL_W-1:0];
         r.status       = STATUS_MEASURE;
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Result channel
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_driver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_stall   = 1'b1;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_stall = ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   initial begin : result_checker
      baro_result_t got, want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.rel_pressure = rsp_rel_pressure;
            got.status       = rsp_status;
            got.clamped      = rsp_clamped;
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: rel %0d status %0d clamped %0d",
                           got.rel_pressure, got.status, got.clamped);
            end else begin
               want = expected_results.pop_front();
               if (want.status == STATUS_REJECT) rejects++;
               if (want.status == STATUS_ACCEPT) accepts++;
               if (want.clamped) clamps++;
               if (got.rel_pressure !== want.rel_pressure || got.status !== want.status ||
                   got.clamped !== want.clamped) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected rel %0d status %0d clamped %0d, %s %0d %0d %0d",
                              results_seen, want.rel_pressure, want.status, want.clamped,
                              "got", got.rel_pressure, got.status, got.clamped);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   function automatic void set_idling(input idle_mode_e m);
      send_idle_pct = (m == IDLE_SENDER) ? 83 : (m == IDLE_BOTH) ? 31 : 0;
      rsp_stall_pct = (m == IDLE_RECEIVER) ? 83 : (m == IDLE_BOTH) ? 31 : 0;
   endfunction

   function automatic logic [P_W-1:0] near_pressure(input int center, input int spread);
      int v;
      v = center + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > int'(P_MAX)) v = P_MAX;
      return P_W'(v);
   endfunction

   task automatic send_item(input logic op, input logic [P_W-1:0] p);
      baro_result_t want;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid           = 1'b1;
      req_opcode          = op;
      req_pressure_sample = p;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (predict_item(op, p, want)) expected_results.insert(expected_results.size(), want);
   endtask

   // drops valid and waits for every outstanding result, then a short tail
   task automatic drain(input int unsigned tail);
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_gate_step(input logic [STEP_W-1:0] v);
      drain(8);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      gate_step_q = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_prearm_directed();
      set_idling(IDLE_NONE);
      // reset gate step, zero baseline
      send_item(OP_SAMPLE, '0);
      send_item(OP_SAMPLE, P_W'(200));
      send_item(OP_SAMPLE, P_W'(P_MAX));
      send_item(OP_SAMPLE, '0);
      send_item(OP_SAMPLE, 21'h0AAAAA);
      send_item(OP_SAMPLE, 21'h155555);
      write_gate_step('0);
      send_item(OP_SAMPLE, '0);
      send_item(OP_SAMPLE, P_W'(P_MAX));
      send_item(OP_SAMPLE, P_W'(-last_rel_q));   // exactly on the previous output
      write_gate_step('1);
      send_item(OP_SAMPLE, P_W'(P_MAX));
      send_item(OP_SAMPLE, '0);
      send_item(OP_SAMPLE, P_W'(1));
   endtask

   task automatic test_prearm_random();
      int unsigned walk_p;
      walk_p = $urandom_range(P_MAX);
      for (int ph = 0; ph < 4; ph++) begin
         write_gate_step(ph == 1 ? STEP_W'($urandom_range(600)) : STEP_W'($urandom));
         set_idling(idle_mode_e'(3 - ph));
         for (int n = 0; n < 75; n++) begin
            if ($urandom_range(99) < 30) walk_p = $urandom_range(P_MAX);
            else walk_p = near_pressure(int'(walk_p), 800);
            send_item(OP_SAMPLE, P_W'(walk_p));
         end
      end
   endtask

   task automatic test_calibration_rounds();
      logic [P_W-1:0] vals [CAL_COUNT];
      logic [P_W-1:0] tmp;
      int unsigned    a, d, c, s, j, k;
      bit             high_side;
      cal_shape_e     shape;
      set_idling(IDLE_NONE);
      send_item(OP_ARM, P_W'($urandom));
      send_item(OP_ARM, P_W'($urandom));   // repeated arm
      for (int r = 0; r < 8 && !calibrated_q; r++) begin
         shape     = (r == 7) ? SET_EDGE_ACCEPT : cal_shape_e'(r % 5);
         a         = $urandom_range(P_MAX - 3001, 2001);
         d         = $urandom_range(1000, 1);
         c         = $urandom_range(P_MAX - 5000, 5000);
         s         = $urandom_range(600, 1);
         high_side = 1'($urandom_range(1));
         set_idling(idle_mode_e'(r % 4));
         for (int i = 0; i < CAL_COUNT; i++) vals[i] = P_W'(c - s + $urandom_range(2 * s));
         case (shape)
            SET_OUTLIER_HIGH, SET_OUTLIER_LOW: begin
               k = $urandom_range(3, 1);
               for (int i = 0; i < k; i++)
                  vals[i] = (shape == SET_OUTLIER_HIGH) ?
                            P_W'(c + 5 * s + 1 + $urandom_range(1000)) :
                            P_W'(c - 5 * s - 1 - $urandom_range(1000));
            end
            SET_FLAT: begin
               for (int i = 0; i < CAL_COUNT; i++) vals[i] = P_W'(P_MAX);
               vals[0] = '0;
            end
            default: begin
               // two levels, plus one point on a quartile bound or just past it
               for (int i = 0; i < CAL_COUNT; i++)
                  vals[i] = P_W'((i < CAL_COUNT / 2) ? a : a + d);
               if (shape == SET_EDGE_HIGH || (shape == SET_EDGE_ACCEPT && high_side))
                  vals[CAL_COUNT-1] = P_W'(a + 3 * d + (shape == SET_EDGE_HIGH));
               else
                  vals[0] = P_W'(a - 2 * d - (shape == SET_EDGE_LOW));
            end
         endcase
         for (int i = CAL_COUNT - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
         end
         for (int i = 0; i < CAL_COUNT; i++) begin
            if ($urandom_range(99) < 4) send_item(OP_ARM, P_W'($urandom));
            send_item(OP_SAMPLE, vals[i]);
         end
         send_item(OP_SAMPLE, P_W'($urandom));   // completing sample
      end
   endtask

   task automatic test_measurement_random();
      logic [STEP_W-1:0] step;
      int unsigned       spread, pick;
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0:       step = '0;
            1:       step = '1;
            2:       step = GATE_STEP_RESET;
            3:       step = STEP_W'(1);
            default: step = STEP_W'($urandom_range(ph == 4 ? 65535 : 2000));
         endcase
         write_gate_step(step);
         set_idling(idle_mode_e'(ph % 4));
         spread = $urandom_range(5000, 20);
         for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(99);
            if (pick < 3) send_item(OP_ARM, P_W'($urandom));
            else if (pick < 8) send_item(OP_SAMPLE, P_W'(pick[0] ? P_MAX : 0));
            else if (pick < 18) send_item(OP_SAMPLE, P_W'($urandom));
            else send_item(OP_SAMPLE, near_pressure(int'(baseline_q), spread));
         end
      end
   endtask

   task automatic test_backpressure();
      set_idling(IDLE_NONE);
      drain(0);
      @(posedge clock);
      hold_cycles = 300;   // result side held off, input fills and stalls
      for (int n = 0; n < 30; n++)
         send_item(OP_SAMPLE, near_pressure(int'(baseline_q), 3000));
      drain(0);            // sender pauses until every result is in
      set_idling(IDLE_BOTH);
      for (int n = 0; n < 30; n++)
         send_item(OP_SAMPLE, near_pressure(int'(baseline_q), 3000));
   endtask

   initial begin : main_sequence
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_opcode          = OP_SAMPLE;
      req_pressure_sample = '0;
      csr_valid           = 1'b0;
      csr_data            = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_prearm_directed();
      test_prearm_random();
      test_calibration_rounds();
      test_measurement_random();
      test_backpressure();
      drain(16);
      mismatches = mismatches + expected_results.size();

      $display("%0d items in, %0d results checked, %0d mismatches", items_sent,
               results_seen, mismatches);
      $display("calibrations rejected %0d, accepted %0d; slew-limited results %0d",
               rejects, accepts, clamps);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/bbcg_pkg.sv
hdl/bbcg_cell.sv
hdl/bbcg_chain.sv
hdl/baro_baseline_calibrate_and_gate.sv
tb/sv/tb.sv
